/* design/spse_pkg.sv */
// ----------------------------------------------------------------------------
// spse_pkg - sorted pin set engine package
// Types, codes and sizes shared by the cell row and the top level.
// ----------------------------------------------------------------------------
package spse_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int PIN_WIDTH   = 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [PIN_WIDTH-1:0] PIN_NONE = '0;
    localparam logic [PIN_WIDTH-1:0] PIN_INF  = '1;

    typedef enum logic [2:0] {
        REQ_CLEAR     = 3'd0,
        REQ_APPEND    = 3'd1,
        REQ_INTERSECT = 3'd2,
        REQ_CONTAINS  = 3'd3,
        REQ_REIFY     = 3'd4,
        REQ_QUERY     = 3'd5
    } t_req_code;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ORDER     = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NO_STAR   = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [PIN_WIDTH-1:0] pin_value;
        logic [PIN_WIDTH-1:0] interval_lower;
        logic [PIN_WIDTH-1:0] interval_upper;
        logic                 star_flag;
    } t_req;

    typedef struct packed {
        logic [2:0]           status;
        logic                 hit;
        logic                 star_now;
        logic [CNT_W-1:0]     pin_count;
        logic [PIN_WIDTH-1:0] bound_low;
        logic [PIN_WIDTH-1:0] bound_high;
    } t_res;

    // broadcast from control to every cell
    typedef struct packed {
        logic                 sample;
        logic [PIN_WIDTH-1:0] pin;
        logic [PIN_WIDTH-1:0] lower;
        logic [PIN_WIDTH-1:0] upper;
        logic [CNT_W-1:0]     win_first;
        logic [CNT_W-1:0]     win_end;
        logic [PIN_WIDTH-1:0] wr_pin;
    } t_cell_bcast;

    // what each cell reports back
    typedef struct packed {
        logic                 keep;
        logic                 is_first;
        logic                 is_last;
        logic                 eq;
        logic [PIN_WIDTH-1:0] pin;
    } t_cell_flags;

endpackage

/* design/spse_cell.sv */
// ----------------------------------------------------------------------------
// spse_cell - one slot of the pin row
// Holds one pin, samples its compares against the incoming beat and marks
// the edges of the kept run from its neighbours' keep bits.
// ----------------------------------------------------------------------------
module spse_cell
    import spse_pkg::*;
(
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_index,
    input  t_cell_bcast        i_bc,
    input  logic               i_wr_en,
    input  logic               i_prev_keep,
    input  logic               i_next_keep,
    output t_cell_flags        o_flags
);

    logic [PIN_WIDTH-1:0] r_pin;
    logic                 r_win;
    logic                 r_lt_upper;
    logic                 r_ge_lower;
    logic                 r_eq;
    logic [CNT_W-1:0]     w_pos;
    logic                 w_keep;

    assign w_pos = {1'b0, i_index};

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pin <= i_bc.wr_pin;
        end
        if (i_bc.sample) begin
            r_win      <= (w_pos >= i_bc.win_first) && (w_pos < i_bc.win_end);
            r_lt_upper <= r_pin < i_bc.upper;
            r_ge_lower <= r_pin >= i_bc.lower;
            r_eq       <= r_pin == i_bc.pin;
        end
    end

    // pins ascend, so the kept cells form one contiguous run
    assign w_keep           = r_win && r_lt_upper && r_ge_lower;
    assign o_flags.keep     = w_keep;
    assign o_flags.is_first = w_keep && !i_prev_keep;
    assign o_flags.is_last  = w_keep && !i_next_keep;
    assign o_flags.eq       = r_win && r_eq;
    assign o_flags.pin      = r_pin;

endmodule

/* design/sorted_pin_set_engine_top.sv */
// ----------------------------------------------------------------------------
// sorted_pin_set_engine_top - ascending pin set with star flag
// Row of pin cells plus window/bounds control; one result beat per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_req)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_res)
//
//  On accept every cell's compares are registered; in S_EVAL the update
//  commits and the result register loads.
//  A new beat is taken only after the previous request has committed.
//  If the result register is still full, the evaluation holds until it drains.
//  Synchronous active-low reset empties the set and clears the star.
// ----------------------------------------------------------------------------
module sorted_pin_set_engine_top
    import spse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_req  i_in_data,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_res  o_out_data
);

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [CNT_W-1:0]     r_first, n_first;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_star, n_star;
    logic [PIN_WIDTH-1:0] r_lo_pin, n_lo_pin;
    logic [PIN_WIDTH-1:0] r_hi_pin, n_hi_pin;
    logic                 r_out_valid;
    t_res                 r_out, n_out;

    logic                    w_accept;
    logic                    w_commit;
    logic [CNT_W-1:0]        w_end;
    t_cell_bcast             w_bc;
    logic [STORE_DEPTH-1:0]  w_wr_en;
    t_cell_flags             w_flags [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]  w_keep;

    logic                    w_any_keep;
    logic                    w_hit_any;
    logic [IDX_W-1:0]        w_first_idx;
    logic [IDX_W-1:0]        w_last_idx;
    logic [PIN_WIDTH-1:0]    w_first_pin;
    logic [PIN_WIDTH-1:0]    w_last_pin;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_end    = r_first + r_count;

    assign w_bc.sample    = w_accept;
    assign w_bc.pin       = i_in_data.pin_value;
    assign w_bc.lower     = i_in_data.interval_lower;
    assign w_bc.upper     = i_in_data.interval_upper;
    assign w_bc.win_first = r_first;
    assign w_bc.win_end   = w_end;
    assign w_bc.wr_pin    = r_req.pin_value;

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        logic w_prev, w_next;
        if (g == 0) begin : g_head
            assign w_prev = 1'b0;
        end else begin : g_mid
            assign w_prev = w_keep[g-1];
        end
        if (g == STORE_DEPTH - 1) begin : g_tail
            assign w_next = 1'b0;
        end else begin : g_body
            assign w_next = w_keep[g+1];
        end
        spse_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (IDX_W'(g)),
            .i_bc        (w_bc),
            .i_wr_en     (w_wr_en[g]),
            .i_prev_keep (w_prev),
            .i_next_keep (w_next),
            .o_flags     (w_flags[g])
        );
        assign w_keep[g] = w_flags[g].keep;
    end

    // one-hot edges of the kept run to index and pin
    always_comb begin
        w_any_keep  = 1'b0;
        w_hit_any   = 1'b0;
        w_first_idx = '0;
        w_last_idx  = '0;
        w_first_pin = '0;
        w_last_pin  = '0;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            w_any_keep = w_any_keep | w_flags[k].keep;
            w_hit_any  = w_hit_any | w_flags[k].eq;
            if (w_flags[k].is_first) begin
                w_first_idx = w_first_idx | IDX_W'(k);
                w_first_pin = w_first_pin | w_flags[k].pin;
            end
            if (w_flags[k].is_last) begin
                w_last_idx = w_last_idx | IDX_W'(k);
                w_last_pin = w_last_pin | w_flags[k].pin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_count     <= '0;
            r_star      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_count <= n_count;
            r_star  <= n_star;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        r_lo_pin <= n_lo_pin;
        r_hi_pin <= n_hi_pin;
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        logic       pin_bad;
        logic [2:0] status;
        logic       hit;

        n_state    = r_state;
        n_first    = r_first;
        n_count    = r_count;
        n_star     = r_star;
        n_lo_pin   = r_lo_pin;
        n_hi_pin   = r_hi_pin;
        w_wr_en    = '0;
        w_commit   = 1'b0;
        o_in_ready = 1'b0;
        status     = ST_OK;
        hit        = 1'b0;
        pin_bad    = (r_req.pin_value == PIN_NONE) || (r_req.pin_value == PIN_INF);

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_out_valid || i_out_ready) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                    case (r_req.req_type)
                        REQ_CLEAR: begin
                            n_first = '0;
                            n_count = '0;
                            n_star  = r_req.star_flag;
                        end
                        REQ_APPEND: begin
                            if (pin_bad) begin
                                status = ST_ORDER;
                            end else if (r_count != '0 && r_req.pin_value < r_hi_pin) begin
                                status = ST_ORDER;
                            end else if (w_end >= CNT_W'(STORE_DEPTH)) begin
                                status = ST_FULL;
                            end else begin
                                w_wr_en[w_end[IDX_W-1:0]] = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_hi_pin = r_req.pin_value;
                                if (r_count == '0) begin
                                    n_lo_pin = r_req.pin_value;
                                end
                            end
                        end
                        REQ_INTERSECT: begin
                            if (w_any_keep) begin
                                n_first  = {1'b0, w_first_idx};
                                n_count  = {1'b0, w_last_idx} - {1'b0, w_first_idx} + 1'b1;
                                n_lo_pin = w_first_pin;
                                n_hi_pin = w_last_pin;
                            end else begin
                                n_first = '0;
                                n_count = '0;
                            end
                            n_star = r_star && (r_req.interval_upper == PIN_INF);
                            if (!w_any_keep && !n_star) begin
                                status = ST_EMPTY;
                            end
                        end
                        REQ_CONTAINS: begin
                            if (r_req.pin_value == PIN_INF) begin
                                hit = r_star;
                            end else if (r_req.pin_value != PIN_NONE) begin
                                hit = w_hit_any;
                            end
                        end
                        REQ_REIFY: begin
                            if (!r_star) begin
                                status = ST_NO_STAR;
                            end else if (pin_bad) begin
                                status = ST_ORDER;
                            end else begin
                                w_wr_en[0] = 1'b1;
                                n_first    = '0;
                                n_count    = CNT_W'(1);
                                n_star     = 1'b0;
                                n_lo_pin   = r_req.pin_value;
                                n_hi_pin   = r_req.pin_value;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.status     = status;
        n_out.hit        = hit;
        n_out.star_now   = n_star;
        n_out.pin_count  = n_count;
        n_out.bound_low  = (n_count != '0) ? n_lo_pin : '0;
        n_out.bound_high = (n_count != '0) ? n_hi_pin + 1'b1 : '0;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* dv/sorted_pin_set_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_pin_set_engine_top_tb - self-checking bench for the sorted pin set
// Directed requests walk the append rules, the full store, trims, membership,
// star reify and the spare codes. Random sequences then build ascending sets
// and work on them, mixed with noise beats. Both channels idle at random and
// every result beat is checked against a behavioural copy of the set.
// ----------------------------------------------------------------------------
module sorted_pin_set_engine_top_tb;
    import spse_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 10;

    // spare request codes, decoded as query
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam logic [PIN_WIDTH-1:0] PIN_TOP = PIN_INF - 1'b1;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_res o_out_data;

    sorted_pin_set_engine_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // behavioural copy of the pin set
    logic [PIN_WIDTH-1:0] set_pins [STORE_DEPTH];
    int unsigned          set_first = 0;
    int unsigned          set_count = 0;
    logic                 set_star  = 1'b0;

    t_res pending_results [$];

    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    int unsigned requests_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned mismatches    = 0;
    int unsigned full_refusals = 0;
    int unsigned member_hits   = 0;
    int unsigned empty_reports = 0;
    int          rx_left       = 0;
    int          rx_mode       = 0;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("FAIL");
        $finish;
    end

    function automatic logic [PIN_WIDTH-1:0] pin_at(int unsigned k);
        if (set_first + k >= STORE_DEPTH)
            return '0;
        return set_pins[set_first + k];
    endfunction

    function automatic t_res apply_request(t_req r);
        t_res        res;
        int unsigned first;
        int unsigned count;
        res = '0;
        case (r.req_type)
            REQ_CLEAR: begin
                set_first = 0;
                set_count = 0;
                set_star  = r.star_flag;
            end
            REQ_APPEND: begin
                if (r.pin_value == PIN_NONE || r.pin_value == PIN_INF)
                    res.status = ST_ORDER;
                else if (set_count > 0 && r.pin_value < pin_at(set_count - 1))
                    res.status = ST_ORDER;
                else if (set_first + set_count >= STORE_DEPTH)
                    res.status = ST_FULL;
                else begin
                    set_pins[set_first + set_count] = r.pin_value;
                    set_count++;
                end
            end
            REQ_INTERSECT: begin
                first = 0;
                count = set_count;
                while (count > 0 && pin_at(first + count - 1) >= r.interval_upper)
                    count--;
                while (count > 0 && pin_at(first) < r.interval_lower) begin
                    first++;
                    count--;
                end
                set_first += first;
                set_count = count;
                if (set_count == 0)
                    set_first = 0;
                set_star = set_star && (r.interval_upper == PIN_INF);
                if (set_count == 0 && !set_star)
                    res.status = ST_EMPTY;
            end
            REQ_CONTAINS: begin
                if (r.pin_value == PIN_INF)
                    res.hit = set_star;
                else if (r.pin_value != PIN_NONE) begin
                    for (int unsigned k = 0; k < set_count; k++)
                        if (pin_at(k) == r.pin_value)
                            res.hit = 1'b1;
                end
            end
            REQ_REIFY: begin
                if (!set_star)
                    res.status = ST_NO_STAR;
                else if (r.pin_value == PIN_NONE || r.pin_value == PIN_INF)
                    res.status = ST_ORDER;
                else begin
                    set_pins[0] = r.pin_value;
                    set_first   = 0;
                    set_count   = 1;
                    set_star    = 1'b0;
                end
            end
            default: ;
        endcase
        res.star_now  = set_star;
        res.pin_count = CNT_W'(set_count);
        if (set_count > 0) begin
            res.bound_low  = pin_at(0);
            res.bound_high = pin_at(set_count - 1) + 1'b1;
        end
        return res;
    endfunction

    function automatic t_req mk_req(logic [2:0] code, logic [PIN_WIDTH-1:0] pin,
                                    logic [PIN_WIDTH-1:0] lower,
                                    logic [PIN_WIDTH-1:0] upper, logic star);
        t_req r;
        r.req_type       = code;
        r.pin_value      = pin;
        r.interval_lower = lower;
        r.interval_upper = upper;
        r.star_flag      = star;
        return r;
    endfunction

    function automatic t_req random_req();
        return mk_req(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                      1'($urandom_range(0, 1)));
    endfunction

    // bound or probe value, often close to a pin already placed in the set
    function automatic logic [PIN_WIDTH-1:0] pick_near(logic [PIN_WIDTH-1:0] pool [$]);
        logic [PIN_WIDTH-1:0] p;
        int                   sel;
        sel = $urandom_range(0, 7);
        p   = '0;
        if (pool.size() == 0)
            sel = 7;
        else
            p = pool[$urandom_range(0, pool.size() - 1)];
        case (sel)
            0, 1:    return p;
            2:       return p + 1'b1;
            3:       return p - 1'b1;
            4:       return PIN_INF;
            5:       return PIN_NONE;
            default: return $urandom;
        endcase
    endfunction

    // sender: bursts of beats with random gaps; valid held until accepted
    task automatic send_request(input t_req r);
        int   gap;
        t_res want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        want = apply_request(r);
        pending_results.push_back(want);
        requests_sent++;
        if (want.status == ST_FULL)  full_refusals++;
        if (want.status == ST_EMPTY) empty_reports++;
        if (want.hit)                member_hits++;
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // receiver: segments of full flow, heavy stall or coin toss
    always @(posedge i_clk) begin : result_side
        t_res want;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = (rx_mode == 0) ? $urandom_range(1, 40) : $urandom_range(1, 16);
        end
        rx_left--;
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 4) == 0);
            default: i_out_ready <= 1'($urandom_range(0, 1));
        endcase

        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, actual %0h", $time,
                         o_out_data);
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (o_out_data.status !== want.status)
                    note_mismatch("status", want.status, o_out_data.status);
                if (o_out_data.hit !== want.hit)
                    note_mismatch("hit", want.hit, o_out_data.hit);
                if (o_out_data.star_now !== want.star_now)
                    note_mismatch("star_now", want.star_now, o_out_data.star_now);
                if (o_out_data.pin_count !== want.pin_count)
                    note_mismatch("pin_count", want.pin_count, o_out_data.pin_count);
                if (o_out_data.bound_low !== want.bound_low)
                    note_mismatch("bound_low", want.bound_low, o_out_data.bound_low);
                if (o_out_data.bound_high !== want.bound_high)
                    note_mismatch("bound_high", want.bound_high, o_out_data.bound_high);
            end
        end
    end

    task automatic test_reset_state();
        send_request(mk_req(REQ_QUERY, '0, '0, '0, 1'b0));
        send_request(mk_req(REQ_CONTAINS, PIN_INF, '0, '0, 1'b0));
    endtask

    // append rules, ending with a full store
    task automatic test_append_and_fill();
        send_request(mk_req(REQ_CLEAR, '0, '0, '0, 1'b1));
        send_request(mk_req(REQ_APPEND, 32'd1, '0, '0, 1'b0));
        send_request(mk_req(REQ_APPEND, 32'd1, '0, '0, 1'b0));   // equal is fine
        send_request(mk_req(REQ_APPEND, PIN_NONE, '0, '0, 1'b0));
        send_request(mk_req(REQ_APPEND, PIN_INF, '0, '0, 1'b0));
        send_request(mk_req(REQ_APPEND, 32'd100, '0, '0, 1'b0));
        send_request(mk_req(REQ_APPEND, 32'd50, '0, '0, 1'b0));  // below last
        for (int k = 1; k <= 12; k++)
            send_request(mk_req(REQ_APPEND, 32'd100 + k * 1000, '0, '0, 1'b0));
        send_request(mk_req(REQ_APPEND, PIN_TOP, '0, '0, 1'b0));
        send_request(mk_req(REQ_APPEND, PIN_TOP, '0, '0, 1'b0)); // no room
    endtask

    task automatic test_contains();
        send_request(mk_req(REQ_CONTAINS, 32'd1, '0, '0, 1'b0));
        send_request(mk_req(REQ_CONTAINS, PIN_NONE, '0, '0, 1'b0));
        send_request(mk_req(REQ_CONTAINS, PIN_INF, '0, '0, 1'b0));
        send_request(mk_req(REQ_CONTAINS, 32'd7, '0, '0, 1'b0));
    endtask

    // bottom trim moves the window up, so the store stays full until emptied
    task automatic test_intersect();
        send_request(mk_req(REQ_INTERSECT, '0, 32'd2, PIN_INF, 1'b0));
        send_request(mk_req(REQ_APPEND, PIN_TOP, '0, '0, 1'b0));
        send_request(mk_req(REQ_INTERSECT, '0, '0, PIN_TOP, 1'b0));
        send_request(mk_req(REQ_INTERSECT, '0, 32'd500, 32'd100, 1'b0));
        send_request(mk_req(REQ_APPEND, 32'd5, '0, '0, 1'b0));
    endtask

    task automatic test_reify();
        send_request(mk_req(REQ_REIFY, 32'd9, '0, '0, 1'b0));
        send_request(mk_req(REQ_CLEAR, '0, '0, '0, 1'b1));
        send_request(mk_req(REQ_REIFY, PIN_NONE, '0, '0, 1'b0));
        send_request(mk_req(REQ_REIFY, PIN_INF, '0, '0, 1'b0));
        send_request(mk_req(REQ_REIFY, 32'h8000_0000, '0, '0, 1'b0));
        send_request(mk_req(REQ_QUERY, '0, '0, '0, 1'b0));
    endtask

    task automatic test_spare_codes();
        send_request(mk_req(REQ_SPARE_A, '1, '1, '1, 1'b1));
        send_request(mk_req(REQ_SPARE_B, '1, '1, '1, 1'b1));
    endtask

    // clear, build an ascending run, then work on it
    task automatic run_pin_sequence();
        t_req                 r;
        logic [PIN_WIDTH-1:0] placed [$];
        longint unsigned      next_pin;
        int                   ops;
        r = random_req();
        r.req_type = REQ_CLEAR;
        send_request(r);
        case ($urandom_range(0, 3))
            0:       next_pin = 1;
            1:       next_pin = $urandom_range(1, 50);
            2:       next_pin = $urandom;
            default: next_pin = PIN_INF - 32'd40;
        endcase
        if (next_pin == 0)
            next_pin = 1;
        ops = $urandom_range(0, 18) + $urandom_range(1, 8);
        for (int n = 0; n < ops; n++) begin
            r = random_req();
            if (n < ops - 8 || $urandom_range(0, 9) < 2) begin
                r.req_type = REQ_APPEND;
                if ($urandom_range(0, 9) == 0) begin
                    // broken beat: invalid, infinity or one below the next pin
                    case ($urandom_range(0, 2))
                        0:       r.pin_value = PIN_NONE;
                        1:       r.pin_value = PIN_INF;
                        default: r.pin_value = (next_pin > 1) ? PIN_WIDTH'(next_pin - 1)
                                                              : PIN_NONE;
                    endcase
                    if (placed.size() == 0 && r.pin_value != PIN_NONE)
                        r.pin_value = PIN_INF;
                end else begin
                    if (next_pin > PIN_TOP)
                        next_pin = PIN_TOP;
                    r.pin_value = PIN_WIDTH'(next_pin);
                    placed.push_back(r.pin_value);
                    case ($urandom_range(0, 3))
                        0:       next_pin += 0;
                        1:       next_pin += $urandom_range(1, 4);
                        2:       next_pin += $urandom_range(1, 5000);
                        default: next_pin += $urandom >> $urandom_range(0, 8);
                    endcase
                end
            end else begin
                case ($urandom_range(0, 7))
                    0, 1, 2: begin
                        r.req_type       = REQ_INTERSECT;
                        r.interval_lower = pick_near(placed);
                        r.interval_upper = pick_near(placed);
                    end
                    3, 4: begin
                        r.req_type  = REQ_CONTAINS;
                        r.pin_value = pick_near(placed);
                    end
                    5: begin
                        r.req_type = REQ_REIFY;
                        if ($urandom_range(0, 2) == 0)
                            r.pin_value = pick_near(placed);
                    end
                    6:       r.req_type = REQ_QUERY;
                    default: r.req_type = REQ_CLEAR;
                endcase
            end
            send_request(r);
        end
    endtask

    task automatic test_random_traffic(input int unsigned budget);
        int unsigned start;
        start = requests_sent;
        while (requests_sent - start < budget) begin
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 4)) send_request(random_req());
            else
                run_pin_sequence();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_state();
        test_append_and_fill();
        test_contains();
        test_intersect();
        test_reify();
        test_spare_codes();
        test_random_traffic(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests, %0d result beats checked, %0d mismatches",
                 requests_sent, beats_checked, mismatches);
        $display("Full-store refusals %0d, membership hits %0d, empty-set reports %0d",
                 full_refusals, member_hits, empty_reports);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
